/* hdl/sist_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the sorted interval set table.
// No dependencies.
package sist_pkg;

   localparam int RESULT_LIMIT = 16;
   localparam int RES_W        = 4;

   typedef enum logic [2:0] {
      REQ_ADD      = 3'd0,
      REQ_REMOVE   = 3'd1,
      REQ_RANGE    = 3'd2,
      REQ_HIGHEST  = 3'd3,
      REQ_COALESCE = 3'd4
   } req_code_type;

   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_PROC,
      ST_SPLIT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [2:0]         req_type;
      logic signed [63:0] start_time;
      logic signed [63:0] end_time;
      logic signed [63:0] gap_limit;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic               found;
      logic signed [63:0] range_start;
      logic signed [63:0] range_end;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic signed [63:0] span_start;
      logic signed [63:0] span_end;
   } entry_type;

   typedef struct packed {
      logic       wr_en;
      logic       bank;
      entry_type  wr_data;
   } mem_ctl_type;

endpackage

/* hdl/sist_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sist_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/sist_engine.sv */
`timescale 1ns / 1ps
// Request sequencer: streams the table out of one bank, rebuilds it into the
// other and raises results. Depends on sist_pkg.
module sist_engine
   import sist_pkg::*;
#(
   parameter int MAX_INTERVALS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  req_type                          req_data,
   output logic                             rsp_valid,
   output rsp_type                          rsp_data,
   output logic [$clog2(MAX_INTERVALS)-1:0] rd_addr,
   input  entry_type                        rd_data,
   output logic [$clog2(MAX_INTERVALS)-1:0] wr_addr,
   output mem_ctl_type                      mem_ctl
);

   localparam int IW = $clog2(MAX_INTERVALS);
   localparam int CW = $clog2(MAX_INTERVALS + 1);
   localparam logic [CW-1:0] CAP = CW'(MAX_INTERVALS);

   state_type          state_ff, state_in;
   req_type            req_ff, req_in;
   logic [IW-1:0]      idx_ff, idx_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [CW-1:0]      m_ff, m_in;
   logic               ovf_ff, ovf_in;
   logic               pend_ff, pend_in;
   logic signed [63:0] ms_ff, ms_in;
   logic signed [63:0] me_ff, me_in;
   logic [RES_W-1:0]   k_ff, k_in;
   entry_type          split_ff, split_in;
   logic               bank_ff, bank_in;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic               w1_v, w2_v;
   entry_type          w1_d, w2_d, wdat;
   logic               wen;
   logic signed [63:0] a, b, s, e;
   logic [63:0]        gap;
   logic               join_gap, last_entry, pend_fit;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         bank_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         bank_ff      <= bank_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff   <= req_in;
      idx_ff   <= idx_in;
      m_ff     <= m_in;
      ovf_ff   <= ovf_in;
      pend_ff  <= pend_in;
      ms_ff    <= ms_in;
      me_ff    <= me_in;
      k_ff     <= k_in;
      split_ff <= split_in;
      rsp_ff   <= rsp_in;
   end

   assign a          = rd_data.span_start;
   assign b          = rd_data.span_end;
   assign s          = req_ff.start_time;
   assign e          = req_ff.end_time;
   assign gap        = $unsigned(a) - $unsigned(me_ff);
   assign join_gap   = !req_ff.gap_limit[63] && (a > me_ff) &&
                       (gap <= $unsigned(req_ff.gap_limit));
   assign last_entry = ((CW'(idx_ff) + CW'(1)) == cnt_ff);
   assign pend_fit   = (m_ff < CAP);

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      m_in         = m_ff;
      ovf_in       = ovf_ff;
      pend_in      = pend_ff;
      ms_in        = ms_ff;
      me_in        = me_ff;
      k_in         = k_ff;
      split_in     = split_ff;
      bank_in      = bank_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      w1_v = 1'b0;
      w2_v = 1'b0;
      w1_d = '0;
      w2_d = '0;
      wen  = 1'b0;
      wdat = '0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in  = req_data;
               idx_in  = '0;
               m_in    = '0;
               ovf_in  = 1'b0;
               pend_in = 1'b1;
               ms_in   = req_data.start_time;
               me_in   = req_data.end_time;
               k_in    = '0;
               rsp_in  = '0;
               rsp_in.last = 1'b1;
               case (req_data.req_type)
                  REQ_ADD, REQ_REMOVE: begin
                     if (req_data.start_time >= req_data.end_time) begin
                        rsp_in.status = STATUS_EMPTY;
                        rsp_valid_in  = 1'b1;
                     end else begin
                        state_in = (cnt_ff == '0) ? ST_FINISH : ST_READ;
                     end
                  end
                  REQ_RANGE, REQ_COALESCE: begin
                     state_in = (cnt_ff == '0) ? ST_FINISH : ST_READ;
                  end
                  REQ_HIGHEST: begin
                     if (cnt_ff == '0) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        idx_in   = IW'(cnt_ff - CW'(1));
                        state_in = ST_READ;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end

         ST_READ: begin
            state_in = ST_PROC;
         end

         ST_PROC: begin
            case (req_ff.req_type)
               REQ_ADD: begin
                  if (b < s) begin
                     w1_v = 1'b1;
                     w1_d = rd_data;
                  end else if (pend_ff && a <= me_ff) begin
                     if (a < ms_ff) ms_in = a;
                     if (b > me_ff) me_in = b;
                  end else if (pend_ff) begin
                     pend_in = 1'b0;
                     w1_v = 1'b1;
                     w1_d = '{span_start: ms_ff, span_end: me_ff};
                     w2_v = 1'b1;
                     w2_d = rd_data;
                  end else begin
                     w1_v = 1'b1;
                     w1_d = rd_data;
                  end
               end
               REQ_REMOVE: begin
                  if (b <= s || a >= e) begin
                     w1_v = 1'b1;
                     w1_d = rd_data;
                  end else if (a < s) begin
                     w1_v = 1'b1;
                     w1_d = '{span_start: a, span_end: s};
                     if (b > e) begin
                        w2_v = 1'b1;
                        w2_d = '{span_start: e, span_end: b};
                     end
                  end else if (b > e) begin
                     w1_v = 1'b1;
                     w1_d = '{span_start: e, span_end: b};
                  end
               end
               REQ_RANGE: begin
                  if (b > s) begin
                     rsp_in.found       = 1'b1;
                     rsp_in.range_start = a;
                     rsp_in.range_end   = b;
                     rsp_valid_in       = 1'b1;
                  end
               end
               REQ_HIGHEST: begin
                  rsp_in.found     = 1'b1;
                  rsp_in.range_end = b;
                  rsp_valid_in     = 1'b1;
               end
               REQ_COALESCE: begin
                  if (idx_ff == '0) begin
                     ms_in = a;
                     me_in = b;
                  end else if (join_gap) begin
                     if (b > me_ff) me_in = b;
                  end else begin
                     rsp_in.found       = 1'b1;
                     rsp_in.range_start = ms_ff;
                     rsp_in.range_end   = me_ff;
                     rsp_in.last        = (k_ff == RES_W'(RESULT_LIMIT - 1));
                     rsp_valid_in       = 1'b1;
                     k_in  = k_ff + RES_W'(1);
                     ms_in = a;
                     me_in = b;
                  end
               end
               default: ;
            endcase

            if (w1_v) begin
               wen  = 1'b1;
               wdat = w1_d;
            end
            // finish early on a hit or when the result run is full
            if (rsp_valid_in) begin
               state_in = ST_IDLE;
            end else if (w2_v) begin
               split_in = w2_d;
               state_in = ST_SPLIT;
            end else if (last_entry) begin
               state_in = ST_FINISH;
            end else begin
               idx_in   = idx_ff + IW'(1);
               state_in = ST_READ;
            end
            if (req_ff.req_type == REQ_COALESCE && rsp_valid_in && !rsp_in.last) begin
               state_in = last_entry ? ST_FINISH : ST_READ;
               idx_in   = last_entry ? idx_ff : idx_ff + IW'(1);
            end
         end

         ST_SPLIT: begin
            wen  = 1'b1;
            wdat = split_ff;
            if (last_entry) begin
               state_in = ST_FINISH;
            end else begin
               idx_in   = idx_ff + IW'(1);
               state_in = ST_READ;
            end
         end

         ST_FINISH: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
            case (req_ff.req_type)
               REQ_ADD, REQ_REMOVE: begin
                  if (req_ff.req_type == REQ_ADD && pend_ff) begin
                     wen  = 1'b1;
                     wdat = '{span_start: ms_ff, span_end: me_ff};
                  end
                  // include the closing write in the overflow check and the count
                  if (ovf_ff || (wen && !pend_fit)) begin
                     rsp_in.status = STATUS_FULL;
                  end else begin
                     cnt_in  = wen ? m_ff + CW'(1) : m_ff;
                     bank_in = !bank_ff;
                  end
               end
               REQ_COALESCE: begin
                  if (cnt_ff != '0) begin
                     rsp_in.found       = 1'b1;
                     rsp_in.range_start = ms_ff;
                     rsp_in.range_end   = me_ff;
                  end
               end
               default: ;
            endcase
            rsp_in.last = 1'b1;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // append into the spare bank; mark overflow instead of writing past the end
      if (wen) begin
         if (pend_fit) begin
            m_in = m_ff + CW'(1);
         end else begin
            ovf_in = 1'b1;
         end
      end
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_ff;
   assign rd_addr         = idx_ff;
   assign wr_addr         = m_ff[IW-1:0];
   assign mem_ctl.wr_en   = wen && pend_fit;
   assign mem_ctl.bank    = bank_ff;
   assign mem_ctl.wr_data = wdat;

endmodule

/* hdl/sorted_interval_set_table.sv */
`timescale 1ns / 1ps
// Top level of the sorted interval set table: two table banks and the
// sequencer. Depends on sist_pkg, sist_ram and sist_engine.
//
// Usage:
//   A request is taken on a rising edge with start high and busy low; req_data
//   carries the request type, the span or query point and the coalesce gap.
//   Each result appears on rsp_data for one cycle with rsp_valid high; the
//   final result of a request has last set. The receiver cannot stall.
//   Timing: empty spans, unknown types and highest end on an empty table put
//   their result out in the cycle right after the accepting edge. Otherwise
//   each stored interval walked passes through an address state and then a
//   registered RAM read state, plus a split state for each extra interval
//   written by an insert or split, then a close-out state strobes the last
//   result; range and highest end stop at the interval they return, and
//   coalesce stops once its result run is full. busy drops as the last result
//   comes out, so the next request can be taken in that cycle. Intervals are
//   read one at a time through the single read port of the live bank.
//   Add and remove rebuild the table into the spare bank and swap banks when
//   done; a rejected request leaves the live bank untouched.
//   Reset empties the table at once (count to zero); no clearing pass.
module sorted_interval_set_table
   import sist_pkg::*;
#(
   parameter int MAX_INTERVALS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int IW = $clog2(MAX_INTERVALS);
   localparam int EW = $bits(entry_type);

   logic [IW-1:0] rd_addr, wr_addr;
   mem_ctl_type   mem_ctl;
   logic [EW-1:0] q0, q1;
   entry_type     rd_data;

   sist_ram #(.WIDTH(EW), .DEPTH(MAX_INTERVALS)) u_bank0 (
      .clock   (clock),
      .wr_en   (mem_ctl.wr_en && mem_ctl.bank),
      .wr_addr (wr_addr),
      .wr_data (mem_ctl.wr_data),
      .rd_addr (rd_addr),
      .rd_data (q0)
   );

   sist_ram #(.WIDTH(EW), .DEPTH(MAX_INTERVALS)) u_bank1 (
      .clock   (clock),
      .wr_en   (mem_ctl.wr_en && !mem_ctl.bank),
      .wr_addr (wr_addr),
      .wr_data (mem_ctl.wr_data),
      .rd_addr (rd_addr),
      .rd_data (q1)
   );

   assign rd_data = mem_ctl.bank ? entry_type'(q1) : entry_type'(q0);

   sist_engine #(.MAX_INTERVALS(MAX_INTERVALS)) u_engine (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .wr_addr   (wr_addr),
      .mem_ctl   (mem_ctl)
   );

endmodule
